// ----- src/ccc_pkg.sv -----
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types, constants and helpers of the calendar clock counter.
// ----------------------------------------------------------------------------
package ccc_pkg;

  // field ranges, all held at year width so one step helper serves them
  localparam logic [13:0] SEC_RANGE   = 14'd60;
  localparam logic [13:0] MIN_RANGE   = 14'd60;
  localparam logic [13:0] HOUR_RANGE  = 14'd24;
  localparam logic [13:0] MONTH_RANGE = 14'd12;
  localparam logic [13:0] YEAR_RANGE  = 14'd9999;

  // state after reset
  localparam logic [5:0]  SEC_RST   = 6'd50;
  localparam logic [5:0]  MIN_RST   = 6'd59;
  localparam logic [4:0]  HOUR_RST  = 5'd23;
  localparam logic [4:0]  DAY_RST   = 5'd0;
  localparam logic [3:0]  MONTH_RST = 4'd1;
  localparam logic [13:0] YEAR_RST  = 14'd2023;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_EN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOUR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MIN  = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_INC  = 2'd1,
    OP_DEC  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    FLD_SEC   = 3'd0,
    FLD_MIN   = 3'd1,
    FLD_HOUR  = 3'd2,
    FLD_YEAR  = 3'd3,
    FLD_MONTH = 3'd4,
    FLD_DAY   = 3'd5
  } field_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] field_index;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  seconds_out;
    logic [5:0]  minutes_out;
    logic [4:0]  hours_out;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [13:0] year_out;
    logic [2:0]  weekday_out;
    logic        alarm_match;
  } out_item_t;

  typedef struct packed {
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } date_t;

  typedef struct packed {
    date_t date;
    logic  alarm_match;
  } snap_t;

  typedef struct packed {
    logic       enable;
    logic [4:0] hour;
    logic [5:0] minute;
  } alarm_cfg_t;

  // y / 100 for y below 10000 by reciprocal multiply, exact over that range
  function automatic logic [6:0] div100(logic [13:0] y);
    logic [26:0] p;
    p = {13'd0, y} * 27'd5243;
    return p[25:19];
  endfunction

endpackage

// ----- src/ccc_update.sv -----
// ----------------------------------------------------------------------------
// ccc_update
// Time and date registers: tick carry chain and single-field adjustment,
// with a registered snapshot of the updated date for the weekday stages.
// ----------------------------------------------------------------------------
module ccc_update import ccc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  in_item_t   in_item,
  output logic       in_ready,
  input  alarm_cfg_t alarm_cfg,
  output logic       s1_valid,
  output snap_t      s1_snap,
  input  logic       s1_ready
);

  logic [5:0]  sec_r,   sec_nxt;
  logic [5:0]  min_r,   min_nxt;
  logic [4:0]  hour_r,  hour_nxt;
  logic [4:0]  day_r,   day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [13:0] year_r,  year_nxt;
  logic        leap_r,  leap_nxt;
  logic        s1_valid_r;
  snap_t       s1_snap_r;

  logic        fire;
  logic        up;
  logic [4:0]  mdays;
  logic [13:0] adj_sec, adj_min, adj_hour, adj_day, adj_month, adj_year;
  logic [6:0]  cent_q;
  logic [13:0] cent_prod;

  // (v +/- 1) mod n, valid while v stays below twice n less one
  function automatic logic [13:0] step_mod(logic [13:0] v, logic dir_up, logic [13:0] n);
    logic [13:0] inc;
    logic [13:0] dec;
    inc = v + 14'd1;
    dec = v - 14'd1;
    if (dir_up) begin
      return (inc >= n) ? inc - n : inc;
    end else if (v == 14'd0) begin
      return n - 14'd1;
    end else begin
      return (dec >= n) ? dec - n : dec;
    end
  endfunction

  assign in_ready = !s1_valid_r || s1_ready;
  assign fire     = in_valid && in_ready;
  assign up       = (in_item.operation == OP_INC);

  always_comb begin
    unique case (month_r)
      4'd1:                      mdays = leap_r ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   mdays = 5'd30;
      default:                   mdays = 5'd31;
    endcase
  end

  assign adj_sec   = step_mod({8'd0, sec_r},   up, SEC_RANGE);
  assign adj_min   = step_mod({8'd0, min_r},   up, MIN_RANGE);
  assign adj_hour  = step_mod({9'd0, hour_r},  up, HOUR_RANGE);
  assign adj_day   = step_mod({9'd0, day_r},   up, {9'd0, mdays});
  assign adj_month = step_mod({10'd0, month_r}, up, MONTH_RANGE);
  assign adj_year  = step_mod(year_r,          up, YEAR_RANGE);

  always_comb begin
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    if (fire) begin
      unique case (in_item.operation)
        OP_TICK: begin
          if ({8'd0, sec_r} >= SEC_RANGE - 14'd1) begin
            sec_nxt = '0;
            if ({8'd0, min_r} >= MIN_RANGE - 14'd1) begin
              min_nxt = '0;
              if ({9'd0, hour_r} >= HOUR_RANGE - 14'd1) begin
                hour_nxt = '0;
                // a day left beyond the month by a month change also rolls here
                if (day_r >= mdays - 5'd1) begin
                  day_nxt = '0;
                  if ({10'd0, month_r} >= MONTH_RANGE - 14'd1) begin
                    month_nxt = '0;
                    year_nxt  = (year_r >= YEAR_RANGE - 14'd1) ? 14'd0 : year_r + 14'd1;
                  end else begin
                    month_nxt = month_r + 4'd1;
                  end
                end else begin
                  day_nxt = day_r + 5'd1;
                end
              end else begin
                hour_nxt = hour_r + 5'd1;
              end
            end else begin
              min_nxt = min_r + 6'd1;
            end
          end else begin
            sec_nxt = sec_r + 6'd1;
          end
        end
        OP_INC, OP_DEC: begin
          unique case (in_item.field_index)
            FLD_SEC:   sec_nxt   = adj_sec[5:0];
            FLD_MIN:   min_nxt   = adj_min[5:0];
            FLD_HOUR:  hour_nxt  = adj_hour[4:0];
            FLD_YEAR:  year_nxt  = adj_year;
            FLD_MONTH: month_nxt = adj_month[3:0];
            FLD_DAY:   day_nxt   = adj_day[4:0];
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // leap flag kept in step with the year register
  assign cent_q    = div100(year_nxt);
  assign cent_prod = ({7'd0, cent_q} << 6) + ({7'd0, cent_q} << 5) + ({7'd0, cent_q} << 2);
  assign leap_nxt  = (year_nxt[1:0] == 2'd0) &&
                     ((cent_prod != year_nxt) || (cent_q[1:0] == 2'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r      <= SEC_RST;
      min_r      <= MIN_RST;
      hour_r     <= HOUR_RST;
      day_r      <= DAY_RST;
      month_r    <= MONTH_RST;
      year_r     <= YEAR_RST;
      leap_r     <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      sec_r   <= sec_nxt;
      min_r   <= min_nxt;
      hour_r  <= hour_nxt;
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
      leap_r  <= leap_nxt;
      if (fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_snap_r.date.seconds <= sec_nxt;
      s1_snap_r.date.minutes <= min_nxt;
      s1_snap_r.date.hours   <= hour_nxt;
      s1_snap_r.date.day     <= day_nxt;
      s1_snap_r.date.month   <= month_nxt;
      s1_snap_r.date.year    <= year_nxt;
      s1_snap_r.alarm_match  <= alarm_cfg.enable && (hour_nxt == alarm_cfg.hour) &&
                                (min_nxt == alarm_cfg.minute);
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_snap  = s1_snap_r;

endmodule

// ----- src/ccc_weekday.sv -----
// ----------------------------------------------------------------------------
// ccc_weekday
// Weekday by Sakamoto's method over two stages (century quotient, then the
// mod-7 fold) and the result register with its handshake.
// ----------------------------------------------------------------------------
module ccc_weekday import ccc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s1_valid,
  input  snap_t     s1_snap,
  output logic      s1_ready,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_stall
);

  logic        s2_valid_r;
  snap_t       s2_snap_r;
  logic [13:0] s2_yp_r;
  logic [6:0]  s2_q_r;
  logic        s2_neg_r;
  logic [5:0]  s2_base_r;
  logic        out_valid_r;
  out_item_t   out_item_r;

  logic        s2_ready;
  logic [3:0]  m_eff;
  logic        jan_feb;
  logic [13:0] yp;
  logic [5:0]  base;
  logic [14:0] tsum;
  logic [14:0] ssum;
  logic [2:0]  wday;

  function automatic logic [2:0] wd_off(logic [3:0] m);
    logic [2:0] r;
    unique case (m)
      4'd0:    r = 3'd0;
      4'd1:    r = 3'd3;
      4'd2:    r = 3'd2;
      4'd3:    r = 3'd5;
      4'd4:    r = 3'd0;
      4'd5:    r = 3'd3;
      4'd6:    r = 3'd5;
      4'd7:    r = 3'd1;
      4'd8:    r = 3'd4;
      4'd9:    r = 3'd6;
      4'd10:   r = 3'd2;
      4'd11:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // 8 is 1 mod 7, so octal digits fold into a small sum
  function automatic logic [2:0] mod7(logic [14:0] s);
    logic [5:0] f;
    logic [3:0] g;
    f = {3'd0, s[2:0]} + {3'd0, s[5:3]} + {3'd0, s[8:6]} +
        {3'd0, s[11:9]} + {3'd0, s[14:12]};
    g = {1'b0, f[5:3]} + {1'b0, f[2:0]};
    if (g >= 4'd7) begin
      g = g - 4'd7;
    end
    return g[2:0];
  endfunction

  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_ready = !s2_valid_r || s2_ready;

  // january and february count in the previous year
  assign m_eff   = (s1_snap.date.month >= MONTH_RANGE[3:0]) ? 4'd0 : s1_snap.date.month;
  assign jan_feb = (m_eff < 4'd2);
  assign yp      = jan_feb ? s1_snap.date.year - 14'd1 : s1_snap.date.year;
  assign base    = {3'd0, wd_off(m_eff)} + {1'b0, s1_snap.date.day} + 6'd1;

  assign tsum = {1'b0, s2_yp_r} + {3'd0, s2_yp_r[13:2]} - {8'd0, s2_q_r} +
                {10'd0, s2_q_r[6:2]};
  // year -1 contributes -1, which is 6 mod 7
  assign ssum = s2_neg_r ? 15'd6 + {9'd0, s2_base_r} : tsum + {9'd0, s2_base_r};
  assign wday = mod7(ssum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_valid && s1_ready) begin
        s2_valid_r <= 1'b1;
      end else if (s2_ready) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_valid_r && s2_ready) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      s2_snap_r <= s1_snap;
      s2_yp_r   <= yp;
      s2_q_r    <= div100(yp);
      s2_neg_r  <= jan_feb && (s1_snap.date.year == 14'd0);
      s2_base_r <= base;
    end
    if (s2_valid_r && s2_ready) begin
      out_item_r.seconds_out <= s2_snap_r.date.seconds;
      out_item_r.minutes_out <= s2_snap_r.date.minutes;
      out_item_r.hours_out   <= s2_snap_r.date.hours;
      out_item_r.day_out     <= s2_snap_r.date.day;
      out_item_r.month_out   <= s2_snap_r.date.month;
      out_item_r.year_out    <= s2_snap_r.date.year;
      out_item_r.weekday_out <= wday;
      out_item_r.alarm_match <= s2_snap_r.alarm_match;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- src/calendar_clock_counter_unit.sv -----
// ----------------------------------------------------------------------------
// calendar_clock_counter_unit
// Real-time calendar counter with alarm compare: second ticks and field
// adjustments in, full date with weekday and alarm match out.
// ----------------------------------------------------------------------------
// throughput: one item per cycle while out_stall is low, through a three-stage pipeline
//   (date update, century quotient, weekday fold and result register)
// reset: valid bits cleared, date set to 23:59:50 on day 0 of month 1 of 2023,
//   alarm registers cleared to disarmed at 00:00
module calendar_clock_counter_unit import ccc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  in_item_t              in_item,
  output logic                  in_stall,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  out_stall,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  alarm_cfg_t alarm_r;
  logic       in_ready;
  logic       s1_valid;
  logic       s1_ready;
  snap_t      s1_snap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALARM_EN:   alarm_r.enable <= cfg_wdata[0];
        CFG_ALARM_HOUR: alarm_r.hour   <= cfg_wdata[4:0];
        CFG_ALARM_MIN:  alarm_r.minute <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  ccc_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_ready  (in_ready),
    .alarm_cfg (alarm_r),
    .s1_valid  (s1_valid),
    .s1_snap   (s1_snap),
    .s1_ready  (s1_ready)
  );

  ccc_weekday u_weekday (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_snap   (s1_snap),
    .s1_ready  (s1_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

  assign in_stall = !in_ready;

endmodule

// ----- src/ccc_checker.sv -----
// ----------------------------------------------------------------------------
// ccc_checker
// Port-level checks of the calendar clock counter, bound to the top level.
// ----------------------------------------------------------------------------
module ccc_checker import ccc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input in_item_t              in_item,
  input logic                  in_stall,
  input logic                  out_valid,
  input out_item_t             out_item,
  input logic                  out_stall,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  // no result survives reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an empty pipeline never pushes back on the input; checked as reset is released
  a_ready_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_stall)
    else $error("input stalled with an empty pipeline");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // every reported time and date field but the day lies in its range
  a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.seconds_out < 6'd60) && (out_item.minutes_out < 6'd60) &&
                  (out_item.hours_out < 5'd24) && (out_item.month_out < 4'd12) &&
                  (out_item.year_out < 14'd9999) && (out_item.weekday_out < 3'd7))
    else $error("result field out of range");

endmodule

bind calendar_clock_counter_unit ccc_checker u_checker (.*);

// ----- tb/calendar_checker.sv -----
// ----------------------------------------------------------------------------
// calendar_checker
// Watches the item and result channels of the calendar counter, keeps its
// own copy of the date and alarm registers, predicts every reading and
// compares it field by field with what the block reports.
// ----------------------------------------------------------------------------
module calendar_checker import ccc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output date_t                 model_now,
  output int                    model_mdays
);

  alarm_cfg_t alarm_regs;
  out_item_t  expected_readings[$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    model_mdays = 31;
    model_now   = '0;
    alarm_regs  = '0;
  end

  function automatic int month_length(int m, int y);
    if (m == 1) return (y % 4 == 0 && (y % 100 != 0 || y % 400 == 0)) ? 29 : 28;
    if (m == 3 || m == 5 || m == 8 || m == 10) return 30;
    return 31;
  endfunction

  function automatic int wrap_step(int v, bit up, int n);
    if (up) return (v + 1) % n;
    if (v == 0) return n - 1;
    return (v - 1) % n;
  endfunction

  // month offsets of the weekday formula
  function automatic int month_offset(int m);
    case (m)
      0, 4:   return 0;
      1, 5:   return 3;
      2, 10:  return 2;
      3, 6:   return 5;
      7:      return 1;
      8, 11:  return 4;
      default: return 6;
    endcase
  endfunction

  function automatic int weekday_of(date_t d);
    int y, m, s;
    y = int'(d.year);
    m = int'(d.month);
    if (m >= 12) m = 0;
    // january and february belong to the previous year, so year 0 gives -1
    if (m < 2) y = y - 1;
    s = y + y / 4 - y / 100 + y / 400 + month_offset(m) + int'(d.day) + 1;
    s = s % 7;
    if (s < 0) s = s + 7;
    return s;
  endfunction

  function automatic date_t next_date(date_t d, in_item_t it);
    int s, mi, h, dy, mo, yr;
    bit up;
    s  = int'(d.seconds);
    mi = int'(d.minutes);
    h  = int'(d.hours);
    dy = int'(d.day);
    mo = int'(d.month);
    yr = int'(d.year);
    up = (it.operation == OP_INC);
    if (it.operation == OP_TICK) begin
      s++;
      if (s >= int'(SEC_RANGE)) begin
        s = 0;
        mi++;
        if (mi >= int'(MIN_RANGE)) begin
          mi = 0;
          h++;
          if (h >= int'(HOUR_RANGE)) begin
            h = 0;
            dy++;
            // an overflowed day also lands here and moves to the next month
            if (dy >= month_length(mo, yr)) begin
              dy = 0;
              mo++;
              if (mo >= int'(MONTH_RANGE)) begin
                mo = 0;
                yr++;
                if (yr >= int'(YEAR_RANGE)) yr = 0;
              end
            end
          end
        end
      end
    end else if (it.operation == OP_INC || it.operation == OP_DEC) begin
      case (it.field_index)
        FLD_SEC:   s  = wrap_step(s, up, int'(SEC_RANGE));
        FLD_MIN:   mi = wrap_step(mi, up, int'(MIN_RANGE));
        FLD_HOUR:  h  = wrap_step(h, up, int'(HOUR_RANGE));
        FLD_YEAR:  yr = wrap_step(yr, up, int'(YEAR_RANGE));
        FLD_MONTH: mo = wrap_step(mo, up, int'(MONTH_RANGE));
        FLD_DAY:   dy = wrap_step(dy, up, month_length(mo, yr));
        default: ;
      endcase
    end
    d.seconds = s[5:0];
    d.minutes = mi[5:0];
    d.hours   = h[4:0];
    d.day     = dy[4:0];
    d.month   = mo[3:0];
    d.year    = yr[13:0];
    return d;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    date_t     nd;
    int        wd;
    if (!rst_n) begin
      model_now.seconds = SEC_RST;
      model_now.minutes = MIN_RST;
      model_now.hours   = HOUR_RST;
      model_now.day     = DAY_RST;
      model_now.month   = MONTH_RST;
      model_now.year    = YEAR_RST;
      alarm_regs        = '0;
      expected_readings.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: reading with no item waiting", $time);
        end else begin
          want = expected_readings.pop_front();
          if (out_item.seconds_out !== want.seconds_out ||
              out_item.minutes_out !== want.minutes_out ||
              out_item.hours_out   !== want.hours_out   ||
              out_item.day_out     !== want.day_out     ||
              out_item.month_out   !== want.month_out   ||
              out_item.year_out    !== want.year_out    ||
              out_item.weekday_out !== want.weekday_out ||
              out_item.alarm_match !== want.alarm_match) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: reading mismatch, expected %0d:%0d:%0d day %0d month %0d year %0d wd %0d alarm %0b",
                       $time, want.hours_out, want.minutes_out, want.seconds_out,
                       want.day_out, want.month_out, want.year_out,
                       want.weekday_out, want.alarm_match);
              $display("%0t:                      got %0d:%0d:%0d day %0d month %0d year %0d wd %0d alarm %0b",
                       $time, out_item.hours_out, out_item.minutes_out, out_item.seconds_out,
                       out_item.day_out, out_item.month_out, out_item.year_out,
                       out_item.weekday_out, out_item.alarm_match);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        nd = next_date(model_now, in_item);
        model_now = nd;
        wd = weekday_of(nd);
        want.seconds_out = nd.seconds;
        want.minutes_out = nd.minutes;
        want.hours_out   = nd.hours;
        want.day_out     = nd.day;
        want.month_out   = nd.month;
        want.year_out    = nd.year;
        want.weekday_out = wd[2:0];
        want.alarm_match = alarm_regs.enable && nd.hours == alarm_regs.hour &&
                           nd.minutes == alarm_regs.minute;
        expected_readings.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ALARM_EN:   alarm_regs.enable = cfg_wdata[0];
          CFG_ALARM_HOUR: alarm_regs.hour   = cfg_wdata[4:0];
          CFG_ALARM_MIN:  alarm_regs.minute = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending     = expected_readings.size();
    model_mdays = month_length(int'(model_now.month), int'(model_now.year));
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives second ticks, field adjustments and alarm settings into the
// calendar counter under random idling and back-pressure; the checker
// beside the block predicts and compares every reading.
// ----------------------------------------------------------------------------
module tb_top;
  import ccc_pkg::*;

  localparam logic [1:0]           OP_UNUSED     = 2'd3;
  localparam logic [2:0]           FLD_UNUSED_LO = 3'd6;
  localparam logic [2:0]           FLD_UNUSED_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_item   = '0;
  logic                  in_stall;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  out_stall = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int    fail_count;
  int    pending;
  int    model_mdays;
  date_t model_now;

  int items_sent = 0;
  int hold_req   = 0;
  int hold_ack   = 0;
  int hold_left  = 0;
  bit quiet      = 1'b0;

  always #2 clk = ~clk;

  calendar_clock_counter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  calendar_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .model_now   (model_now),
    .model_mdays (model_mdays)
  );

  // reading side: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = 150;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 32);
    end
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic [1:0] op, input logic [2:0] fld);
    while (!quiet && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= {op, fld};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic tick_n(input int n);
    logic [31:0] r;
    repeat (n) begin
      r = $urandom;
      send_item(OP_TICK, r[2:0]);
    end
  endtask

  // steps one field to a target by the shorter way round
  task automatic move_to(input field_t f, input int target);
    int cur, span;
    forever begin
      span = int'(SEC_RANGE);
      case (f)
        FLD_SEC:   cur = int'(model_now.seconds);
        FLD_MIN:   cur = int'(model_now.minutes);
        FLD_HOUR:  begin cur = int'(model_now.hours); span = int'(HOUR_RANGE); end
        FLD_YEAR:  begin cur = int'(model_now.year);  span = int'(YEAR_RANGE); end
        FLD_MONTH: begin cur = int'(model_now.month); span = int'(MONTH_RANGE); end
        default:   begin cur = int'(model_now.day);   span = model_mdays; end
      endcase
      if (cur == target) break;
      if (cur >= span || (target - cur + span) % span > span / 2) send_item(OP_DEC, f);
      else send_item(OP_INC, f);
    end
  endtask

  task automatic to_day_end_edge();
    move_to(FLD_HOUR, 23);
    move_to(FLD_MIN, 59);
    move_to(FLD_SEC, 59);
  endtask

  // drop valid and wait until every reading has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_alarm(input logic [5:0] en, input logic [5:0] hr,
                             input logic [5:0] mn);
    logic [31:0] r;
    r = $urandom;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ALARM_EN;
    cfg_wdata <= en;
    @(negedge clk);
    cfg_index <= CFG_ALARM_HOUR;
    cfg_wdata <= hr;
    @(negedge clk);
    cfg_index <= CFG_ALARM_MIN;
    cfg_wdata <= mn;
    @(negedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= r[5:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic rearm();
    logic [31:0] r;
    r = $urandom;
    settle();
    case (r[2:0])
      3'd0: write_alarm(6'd1, 6'd0, 6'd0);
      3'd1: write_alarm(6'd1, 6'd23, 6'd59);
      3'd2: write_alarm(6'd1, 6'd31, 6'd63);
      3'd3: write_alarm(6'd0, {1'b0, model_now.hours}, model_now.minutes);
      3'd4, 3'd5: write_alarm({r[8:4], 1'b1}, {r[9], model_now.hours}, model_now.minutes);
      default: write_alarm(r[13:8], r[19:14], r[25:20]);
    endcase
  endtask

  initial begin : stimulus
    logic [31:0] r;
    int seq_no, lvl, tgt, base;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    write_alarm(6'd1, 6'd0, 6'd0);

    // midnight carry from the reset time, with the alarm at 00:00
    tick_n(10);
    // each field: a step down, then back up; the time fields wrap below zero
    for (int f = 0; f < 6; f++) begin
      send_item(OP_DEC, f[2:0]);
      send_item(OP_INC, f[2:0]);
    end
    // unused operation and unused fields leave the date alone
    send_item(OP_UNUSED, FLD_UNUSED_HI);
    send_item(OP_INC, FLD_UNUSED_LO);
    send_item(OP_DEC, FLD_UNUSED_HI);
    send_item(OP_UNUSED, FLD_SEC);

    // carry from the last second of december into the next year
    settle();
    write_alarm(6'd1, 6'd23, 6'd59);
    hold_req++;
    move_to(FLD_MONTH, 11);
    move_to(FLD_DAY, model_mdays - 1);
    move_to(FLD_HOUR, 23);
    move_to(FLD_MIN, 59);
    move_to(FLD_SEC, 58);
    tick_n(3);

    seq_no = 0;
    base   = items_sent;
    while (items_sent - base < 800) begin
      seq_no++;
      if (seq_no % 8 == 0) rearm();
      if (seq_no == 12) hold_req++;
      quiet = (seq_no >= 20 && seq_no < 30);
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 8)) begin
            r = $urandom;
            send_item(r[1:0], r[4:2]);
          end
        end
        2, 3, 4: begin
          // carry chain as far as lvl reaches
          lvl = $urandom_range(0, 4);
          if (lvl >= 4) move_to(FLD_MONTH, 11);
          if (lvl >= 3) move_to(FLD_DAY, model_mdays - 1);
          if (lvl >= 2) move_to(FLD_HOUR, 23);
          if (lvl >= 1) move_to(FLD_MIN, 59);
          move_to(FLD_SEC, $urandom_range(55, 59));
          tick_n($urandom_range(1, 8));
        end
        5, 6: begin
          // late day, then a month change that leaves it beyond the month's end
          tgt = $urandom_range(27, 30);
          if (tgt >= model_mdays) tgt = model_mdays - 1;
          move_to(FLD_DAY, tgt);
          r = $urandom;
          case (r[2:0])
            3'd0: tgt = 1;
            3'd1: tgt = 3;
            3'd2: tgt = 5;
            3'd3: tgt = 8;
            3'd4: tgt = 10;
            default: tgt = $urandom_range(0, 11);
          endcase
          move_to(FLD_MONTH, tgt);
          case ($urandom_range(0, 2))
            0: repeat ($urandom_range(1, 3)) begin
              r = $urandom;
              send_item(r[0] ? OP_INC : OP_DEC, FLD_DAY);
            end
            1: begin
              to_day_end_edge();
              tick_n($urandom_range(1, 3));
            end
            default: tick_n($urandom_range(1, 4));
          endcase
        end
        7: begin
          // leap february around nearby years, centuries and 400-year marks
          lvl = $urandom_range(0, 9);
          tgt = int'(model_now.year);
          if (lvl < 6) tgt = tgt + int'($urandom_range(0, 8)) - 4;
          else if (lvl < 9) tgt = ((tgt + 50) / 100) * 100 + (int'($urandom_range(0, 2)) - 1) * 100;
          else tgt = ((tgt + 200) / 400) * 400;
          tgt = (tgt + 9999) % 9999;
          move_to(FLD_YEAR, tgt);
          move_to(FLD_MONTH, 1);
          move_to(FLD_DAY, model_mdays - 1 - int'($urandom_range(0, 1)));
          case ($urandom_range(0, 2))
            0: repeat ($urandom_range(1, 3)) begin
              r = $urandom;
              send_item(r[0] ? OP_INC : OP_DEC, FLD_DAY);
            end
            1: begin
              to_day_end_edge();
              tick_n($urandom_range(1, 3));
            end
            default: tick_n($urandom_range(1, 4));
          endcase
        end
        default: begin
          repeat ($urandom_range(1, 10)) begin
            r   = $urandom;
            tgt = $urandom_range(0, 5);
            send_item(r[0] ? OP_INC : OP_DEC, tgt[2:0]);
          end
          tick_n($urandom_range(0, 3));
        end
      endcase
    end
    quiet = 1'b0;

    settle();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
